FILE: src/bounded_list_engine_macros.svh
// assertion macros used by the bounded list engine datapath
// expects clk and rst_n in the scope of each use
`ifndef BOUNDED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_LIST_ENGINE_MACROS_SVH

// condition holds at every edge out of reset
`define BLE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BLE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define BLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ble_pkg.sv
// types, codes and constants of the bounded list engine
// no dependencies; used by every module of the block
package ble_pkg;

    localparam int DEPTH_DEF = 16;

    localparam logic [2:0] KIND_APPEND   = 3'd0;
    localparam logic [2:0] KIND_PREPEND  = 3'd1;
    localparam logic [2:0] KIND_REM_HEAD = 3'd2;
    localparam logic [2:0] KIND_REM_TAIL = 3'd3;
    localparam logic [2:0] KIND_REM_VAL  = 3'd4;
    localparam logic [2:0] KIND_SORT     = 3'd5;
    localparam logic [2:0] KIND_DUMP     = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] item_value;
        logic [3:0]         position;
        logic [4:0]         length;
        logic               last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RV_RD,
        S_RV_CHK,
        S_SO_CHKI,
        S_SO_LDC,
        S_SO_RDJ,
        S_SO_CMP,
        S_DU_RD,
        S_DU_OUT,
        S_FIN
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic rv_read;
        logic rv_check;
        logic rv_commit;
        logic so_read_i;
        logic so_load_cur;
        logic so_read_j;
        logic so_cmp;
        logic so_write_i;
        logic du_read;
        logic du_emit;
        logic fin_emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] kind;
        logic       empty;
        logic       i_lt;
        logic       i_more;
        logic       i_last;
        logic       j_lt;
        logic       out_free;
    } dp_stat_t;

endpackage

FILE: src/ble_ctrl.sv
// sequencer of the bounded list engine: walks each operation through its steps
// depends on ble_pkg; drives the datapath command struct
module ble_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ble_pkg::dp_stat_t stat,
    output ble_pkg::dp_cmd_t  cmd
);
    import ble_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.empty)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    case (stat.kind)
                        KIND_REM_VAL: state_next = S_RV_RD;
                        KIND_SORT:    state_next = S_SO_CHKI;
                        KIND_DUMP:    state_next = S_DU_RD;
                        default:      state_next = S_FIN;
                    endcase
                end
            end
            S_RV_RD:
            begin
                if (stat.i_lt)
                begin
                    cmd.rv_read = 1'b1;
                    state_next  = S_RV_CHK;
                end
                else
                begin
                    cmd.rv_commit = 1'b1;
                    state_next    = S_FIN;
                end
            end
            S_RV_CHK:
            begin
                cmd.rv_check = 1'b1;
                state_next   = S_RV_RD;
            end
            S_SO_CHKI:
            begin
                if (stat.i_more)
                begin
                    cmd.so_read_i = 1'b1;
                    state_next    = S_SO_LDC;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SO_LDC:
            begin
                cmd.so_load_cur = 1'b1;
                state_next      = S_SO_RDJ;
            end
            S_SO_RDJ:
            begin
                if (stat.j_lt)
                begin
                    cmd.so_read_j = 1'b1;
                    state_next    = S_SO_CMP;
                end
                else
                begin
                    // pass over: running maximum goes back to position i
                    cmd.so_write_i = 1'b1;
                    state_next     = S_SO_CHKI;
                end
            end
            S_SO_CMP:
            begin
                cmd.so_cmp = 1'b1;
                state_next = S_SO_RDJ;
            end
            S_DU_RD:
            begin
                cmd.du_read = 1'b1;
                state_next  = S_DU_OUT;
            end
            S_DU_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.du_emit = 1'b1;
                    state_next  = stat.i_last ? S_IDLE : S_DU_RD;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.fin_emit = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/ble_dp.sv
// datapath of the bounded list engine: circular entry store, counters, output register
// depends on ble_pkg and bounded_list_engine_macros.svh
`include "bounded_list_engine_macros.svh"

module ble_dp #(
    parameter int DEPTH = ble_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ble_pkg::in_item_t in_data,
    input  ble_pkg::dp_cmd_t  cmd,
    output ble_pkg::dp_stat_t stat,
    output logic              out_valid,
    input  logic              out_ready,
    output ble_pkg::out_item_t out_data
);
    import ble_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int SW = AW + 2;

    // logical index to physical address, head based
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [FW-1:0] idx);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(idx);
        if (sum >= SW'(DEPTH))
            sum = sum - SW'(DEPTH);
        return sum[AW-1:0];
    endfunction

    logic signed [31:0] mem [DEPTH];

    logic [AW-1:0]      head_reg, head_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [FW-1:0]      i_reg, i_next;
    logic [FW-1:0]      j_reg, j_next;
    logic [FW-1:0]      w_reg, w_next;
    logic               out_valid_reg, out_valid_next;

    logic [2:0]         kind_reg, kind_next;
    logic signed [31:0] val_reg, val_next;
    logic signed [31:0] cur_reg, cur_next;
    logic [1:0]         status_reg, status_next;
    out_item_t          out_reg, out_next;
    logic signed [31:0] rd_data_reg;

    logic               full;
    logic               empty;
    logic               out_free;
    logic               load_out;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [FW:0]        i_plus;

    assign full     = (fill_reg == FW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign out_free = !out_valid_reg || out_ready;
    assign i_plus   = {1'b0, i_reg} + 1'b1;
    assign load_out = cmd.du_emit || cmd.fin_emit;

    assign stat.kind     = kind_reg;
    assign stat.empty    = empty;
    assign stat.i_lt     = (i_reg < fill_reg);
    assign stat.i_more   = (i_plus < {1'b0, fill_reg});
    assign stat.i_last   = (i_plus == {1'b0, fill_reg});
    assign stat.j_lt     = (j_reg < fill_reg);
    assign stat.out_free = out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        head_next      = head_reg;
        fill_next      = fill_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        w_next         = w_reg;
        kind_next      = kind_reg;
        val_next       = val_reg;
        cur_next       = cur_reg;
        status_next    = status_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = phys(head_reg, fill_reg);
        wr_data        = val_reg;
        rd_en          = cmd.rv_read || cmd.so_read_i || cmd.so_read_j || cmd.du_read;
        rd_addr        = phys(head_reg, cmd.so_read_j ? j_reg : i_reg);

        if (out_ready)
            out_valid_next = 1'b0;

        if (cmd.load)
        begin
            kind_next = in_data.kind;
            val_next  = in_data.value;
        end

        if (cmd.exec)
        begin
            i_next      = '0;
            w_next      = '0;
            status_next = ST_OK;
            case (kind_reg)
                KIND_APPEND:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                KIND_PREPEND:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        head_next = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
                        wr_en     = 1'b1;
                        wr_addr   = head_next;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                KIND_REM_HEAD:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                        fill_next = fill_reg - 1'b1;
                    end
                end
                KIND_REM_TAIL:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                        fill_next = fill_reg - 1'b1;
                end
                KIND_REM_VAL, KIND_SORT, KIND_DUMP:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end

        // compaction: keep entries that differ, writer trails reader
        if (cmd.rv_check)
        begin
            i_next = i_reg + 1'b1;
            if (rd_data_reg != val_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, w_reg);
                wr_data = rd_data_reg;
                w_next  = w_reg + 1'b1;
            end
        end

        if (cmd.rv_commit)
            fill_next = w_reg;

        if (cmd.so_load_cur)
        begin
            cur_next = rd_data_reg;
            j_next   = i_reg + 1'b1;
        end

        // exchange: larger entry moves up to position i, old one lands at j
        if (cmd.so_cmp)
        begin
            j_next = j_reg + 1'b1;
            if (rd_data_reg > cur_reg)
            begin
                wr_en    = 1'b1;
                wr_addr  = phys(head_reg, j_reg);
                wr_data  = cur_reg;
                cur_next = rd_data_reg;
            end
        end

        if (cmd.so_write_i)
        begin
            wr_en   = 1'b1;
            wr_addr = phys(head_reg, i_reg);
            wr_data = cur_reg;
            i_next  = i_reg + 1'b1;
        end

        if (cmd.du_emit)
        begin
            out_next.status     = ST_OK;
            out_next.item_value = rd_data_reg;
            out_next.position   = 4'(i_reg);
            out_next.length     = 5'(fill_reg);
            out_next.last       = stat.i_last;
            i_next              = i_reg + 1'b1;
        end

        if (cmd.fin_emit)
        begin
            out_next.status     = status_reg;
            out_next.item_value = '0;
            out_next.position   = '0;
            out_next.length     = 5'(fill_reg);
            out_next.last       = 1'b1;
        end

        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            w_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            w_reg         <= w_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        val_reg    <= val_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    `BLE_ASSERT_ALWAYS(a_fill_bound, fill_reg <= FW'(DEPTH), "fill count beyond depth")
    `BLE_ASSERT_SAME(a_no_overwrite, load_out, out_free, "result register overwritten")
    `BLE_ASSERT_SAME(a_dump_in_range, cmd.du_emit, i_reg < fill_reg, "dump past fill")
    `BLE_ASSERT_NEXT(a_append_grows, cmd.exec && kind_reg == KIND_APPEND && !full,
        fill_reg == $past(fill_reg) + 1'b1, "append did not grow list")

endmodule

FILE: src/bounded_list_engine.sv
// simple ops (append, prepend, remove head/tail, no-op): executed in EXEC, result loaded
// in FIN once the result register is free; a new item is taken only back in IDLE
// remove value: RV_RD, RV_CHK per entry; sort: SO_RDJ, SO_CMP per compared pair
// dump: DU_RD, DU_OUT per entry, waits on stalls; one result register decouples sides
// reset clears head, fill and control; list reads empty, stored words are not cleared
module bounded_list_engine #(
    parameter int DEPTH = ble_pkg::DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ble_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ble_pkg::out_item_t out_data
);
    import ble_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ble_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ble_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for the bounded list engine: a shadow list predicts every result
// depends on ble_pkg and bounded_list_engine from src; nothing else is read
// drives directed and random list operations under random input and output stalls

class list_shadow;
    logic signed [31:0]  shadow_list[$];
    ble_pkg::out_item_t  pending_results[$];
    int                  mismatches;
    int                  results_seen;
    int                  full_drops;
    int                  empty_hits;

    function new();
        mismatches   = 0;
        results_seen = 0;
        full_drops   = 0;
        empty_hits   = 0;
    endfunction

    // one operation on the shadow list, queueing the results it should produce
    function void apply_op(ble_pkg::in_item_t op);
        ble_pkg::out_item_t res;
        logic signed [31:0] kept[$];
        logic signed [31:0] tmp;
        logic [1:0]         st;
        int                 n;

        st = ble_pkg::ST_OK;
        n  = shadow_list.size();
        case (op.kind)
            ble_pkg::KIND_APPEND:
                if (n >= ble_pkg::DEPTH_DEF)
                    st = ble_pkg::ST_FULL;
                else
                    shadow_list.push_back(op.value);
            ble_pkg::KIND_PREPEND:
                if (n >= ble_pkg::DEPTH_DEF)
                    st = ble_pkg::ST_FULL;
                else
                    shadow_list.push_front(op.value);
            ble_pkg::KIND_REM_HEAD:
                if (n == 0)
                    st = ble_pkg::ST_EMPTY;
                else
                    void'(shadow_list.pop_front());
            ble_pkg::KIND_REM_TAIL:
                if (n == 0)
                    st = ble_pkg::ST_EMPTY;
                else
                    void'(shadow_list.pop_back());
            ble_pkg::KIND_REM_VAL:
                if (n == 0)
                    st = ble_pkg::ST_EMPTY;
                else
                begin
                    foreach (shadow_list[i])
                        if (shadow_list[i] != op.value)
                            kept.push_back(shadow_list[i]);
                    shadow_list = kept;
                end
            ble_pkg::KIND_SORT:
                if (n == 0)
                    st = ble_pkg::ST_EMPTY;
                else
                begin
                    // exchange sort, largest first, signed compare
                    for (int i = 0; i + 1 < n; i++)
                        for (int j = i + 1; j < n; j++)
                            if (shadow_list[j] > shadow_list[i])
                            begin
                                tmp            = shadow_list[i];
                                shadow_list[i] = shadow_list[j];
                                shadow_list[j] = tmp;
                            end
                end
            ble_pkg::KIND_DUMP:
            begin
                if (n == 0)
                begin
                    empty_hits++;
                    res            = '0;
                    res.status     = ble_pkg::ST_EMPTY;
                    res.last       = 1'b1;
                    pending_results.push_back(res);
                    return;
                end
                for (int i = 0; i < n; i++)
                begin
                    res            = '0;
                    res.status     = ble_pkg::ST_OK;
                    res.item_value = shadow_list[i];
                    res.position   = i[3:0];
                    res.length     = 5'(n);
                    res.last       = (i == n - 1);
                    pending_results.push_back(res);
                end
                return;
            end
            default:
                ;
        endcase
        if (st == ble_pkg::ST_FULL)
            full_drops++;
        if (st == ble_pkg::ST_EMPTY)
            empty_hits++;
        res        = '0;
        res.status = st;
        res.length = 5'(shadow_list.size());
        res.last   = 1'b1;
        pending_results.push_back(res);
    endfunction

    function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function void match_result(ble_pkg::out_item_t got);
        ble_pkg::out_item_t want;
        bit                 ok;

        results_seen++;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        ok = field_ok("status", want.status, got.status)
           & field_ok("item_value", want.item_value, got.item_value)
           & field_ok("position", want.position, got.position)
           & field_ok("length", want.length, got.length)
           & field_ok("last", want.last, got.last);
        if (!ok)
            mismatches++;
    endfunction
endclass

module tb_top;
    import ble_pkg::*;

    localparam int         DEPTH       = DEPTH_DEF;
    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int         RANDOM_OPS  = 420;
    localparam int         HOLD_CYCLES = 300;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    list_shadow shadow;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         ops_sent;
    bit         hold_req;

    bounded_list_engine #(
        .DEPTH(DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one operation and wait for its transfer
    task automatic push_op(logic [2:0] kind, logic signed [31:0] value);
        in_item_t op;
        int       gap;

        op.kind  = kind;
        op.value = value;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= op;
        do
            @(posedge clk);
        while (!in_ready);
        shadow.apply_op(op);
        ops_sent++;
    endtask

    // often values already in the list or near zero, so removals and sorts see ties
    function automatic logic signed [31:0] pick_value(bit prefer_present);
        int r;
        int n;

        n = shadow.shadow_list.size();
        r = $urandom_range(0, 99);
        if (n > 0 && r < (prefer_present ? 60 : 20))
            return shadow.shadow_list[$urandom_range(0, n - 1)];
        r = $urandom_range(0, 99);
        if (r < 30)
            return $signed($urandom_range(0, 4)) - 2;
        if (r < 45)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic random_op();
        int r;

        r = $urandom_range(0, 99);
        if (r < 25)
            push_op(KIND_APPEND, pick_value(1'b0));
        else if (r < 45)
            push_op(KIND_PREPEND, pick_value(1'b0));
        else if (r < 53)
            push_op(KIND_REM_HEAD, $urandom);
        else if (r < 61)
            push_op(KIND_REM_TAIL, $urandom);
        else if (r < 73)
            push_op(KIND_REM_VAL, pick_value(1'b1));
        else if (r < 83)
            push_op(KIND_SORT, $urandom);
        else if (r < 97)
            push_op(KIND_DUMP, $urandom);
        else
            push_op(KIND_UNUSED, $urandom);
    endtask

    // receive side: check every transfer, stall at random or for a long hold
    initial
    begin
        int hold_left;

        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                shadow.match_result(out_data);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int start;
        int burst_at;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        hold_req      = 1'b0;
        ops_sent      = 0;
        send_idle_pct = 34;
        recv_idle_pct = 50;
        shadow        = new();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list on every kind but prepend, then extremes, one-entry sort, ties and misses
        push_op(KIND_DUMP, 32'sh0);
        push_op(KIND_REM_HEAD, 32'sh0);
        push_op(KIND_REM_TAIL, -32'sd1);
        push_op(KIND_REM_VAL, 32'sh0);
        push_op(KIND_SORT, 32'sh0);
        push_op(KIND_UNUSED, 32'sh0);
        push_op(KIND_APPEND, 32'sh7fff_ffff);
        push_op(KIND_SORT, 32'sh0);
        push_op(KIND_PREPEND, 32'sh8000_0000);
        push_op(KIND_APPEND, -32'sd1);
        push_op(KIND_APPEND, 32'sh0);
        push_op(KIND_PREPEND, 32'sh0);
        push_op(KIND_REM_VAL, 32'sd12345);
        push_op(KIND_SORT, -32'sd1);
        push_op(KIND_DUMP, -32'sd1);
        push_op(KIND_REM_VAL, 32'sh0);
        push_op(KIND_REM_HEAD, 32'sh0);
        push_op(KIND_REM_TAIL, 32'sh0);
        push_op(KIND_UNUSED, -32'sd1);
        push_op(KIND_DUMP, 32'sh0);

        start    = ops_sent;
        burst_at = 35;
        while (ops_sent - start < RANDOM_OPS)
        begin
            if (ops_sent - start >= 2 * RANDOM_OPS / 3)
            begin
                if (send_idle_pct != 0 || recv_idle_pct != 0)
                    hold_req = 1'b1;
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (ops_sent - start >= RANDOM_OPS / 3)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 34;
            end

            if (ops_sent - start >= burst_at)
            begin
                // alternate between filling past full and draining to empty
                if ((burst_at / 35) % 2 == 1)
                begin
                    while (shadow.shadow_list.size() < DEPTH)
                        push_op($urandom_range(0, 1) ? KIND_APPEND : KIND_PREPEND,
                                pick_value(1'b0));
                    push_op($urandom_range(0, 1) ? KIND_APPEND : KIND_PREPEND, $urandom);
                    push_op(KIND_SORT, $urandom);
                    push_op(KIND_DUMP, $urandom);
                end
                else
                begin
                    while (shadow.shadow_list.size() > 0)
                        push_op($urandom_range(0, 1) ? KIND_REM_HEAD : KIND_REM_TAIL,
                                $urandom);
                    push_op(KIND_REM_VAL, pick_value(1'b0));
                    push_op(KIND_DUMP, $urandom);
                end
                burst_at += 35;
            end
            else
                random_op();
        end
        in_valid <= 1'b0;

        while (shadow.pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("%0d list operations driven, %0d results checked, %0d mismatches",
                 ops_sent, shadow.results_seen, shadow.mismatches);
        $display("%0d values dropped on a full list, %0d operations on an empty list",
                 shadow.full_drops, shadow.empty_hits);
        if (shadow.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results still outstanding", shadow.pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
